// ===== rtl/core/pending_downlink_table_core_assert.svh =====
// Assertion macros used by the pending downlink table sequencer.
`ifndef PENDING_DOWNLINK_TABLE_CORE_ASSERT_SVH
`define PENDING_DOWNLINK_TABLE_CORE_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PDT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdt assertion failed");

// Check that a condition implies another in the next cycle.
`define PDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdt assertion failed");

`endif

// ===== rtl/core/pdt_pkg.sv =====
// Types and constants of the pending downlink table.
package pdt_pkg;

    // Event kinds
    localparam logic [1:0] KIND_ENQ   = 2'd0;
    localparam logic [1:0] KIND_HEARD = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    // Result status codes
    localparam logic [3:0] STAT_HELD     = 4'd0;
    localparam logic [3:0] STAT_REPLACED = 4'd1;
    localparam logic [3:0] STAT_FULL     = 4'd2;
    localparam logic [3:0] STAT_BCAST    = 4'd3;
    localparam logic [3:0] STAT_SENT     = 4'd4;
    localparam logic [3:0] STAT_EXPIRED  = 4'd5;
    localparam logic [3:0] STAT_NONE     = 4'd6;
    localparam logic [3:0] STAT_ACKED    = 4'd7;
    localparam logic [3:0] STAT_ACK_MISS = 4'd8;

    // Register indexes, reset values and the attempt count limit
    localparam logic REG_TTL   = 1'b0;
    localparam logic REG_BCAST = 1'b1;
    localparam logic [15:0] TTL_RESET   = 16'd1800;
    localparam logic [15:0] BCAST_RESET = 16'hFFFF;
    localparam logic [7:0]  ATT_MAX     = 8'd255;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] node_address;
        logic [15:0] frame_tag;
        logic [7:0]  frame_length;
        logic [31:0] epoch_now;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        send_valid;
        logic [15:0] send_tag;
        logic [7:0]  send_length;
        logic [7:0]  send_attempts;
    } out_item_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] tag;
        logic [7:0]  len;
        logic [31:0] stamp;
        logic [7:0]  att;
    } slot_t;

    typedef struct packed {
        logic  we;
        logic  valid_set;
        logic  valid_clr;
        slot_t data;
    } slot_wr_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
        logic        zero;
    } alu_rsp_t;

    typedef struct packed {
        logic [15:0] ttl;
        logic [15:0] bcast;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_AGE,
        S_TTL,
        S_WRITE
    } state_t;

endpackage

// ===== rtl/core/pdt_cfg_regs.sv =====
// APB configuration registers: time-to-live and broadcast address.
module pdt_cfg_regs
    import pdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] ttl_reg;
    logic [15:0] bcast_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg   <= TTL_RESET;
            bcast_reg <= BCAST_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_TTL:   ttl_reg   <= pwdata[15:0];
                REG_BCAST: bcast_reg <= pwdata[15:0];
                default:   ttl_reg   <= ttl_reg;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_TTL:   prdata = {16'b0, ttl_reg};
            REG_BCAST: prdata = {16'b0, bcast_reg};
            default:   prdata = 32'b0;
        endcase
    end

    assign cfg.ttl   = ttl_reg;
    assign cfg.bcast = bcast_reg;

endmodule

// ===== rtl/core/pdt_alu.sv =====
// Shared subtract unit: address match, age and time-to-live compare.
module pdt_alu
    import pdt_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [32:0] full;

    // Subtract with borrow out
    assign full       = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.diff   = full[31:0];
    assign rsp.borrow = full[32];
    assign rsp.zero   = (full[31:0] == 32'd0);

endmodule

// ===== rtl/core/pdt_slot_store.sv =====
// Slot memory with registered read and per-slot valid bits.
module pdt_slot_store
    import pdt_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int IDX_W      = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_idx,
    output slot_t                 rd_data,
    input  logic [IDX_W-1:0]      wr_idx,
    input  slot_wr_t              wr,
    output logic [SLOT_COUNT-1:0] valid
);

    slot_t                 mem [SLOT_COUNT];
    slot_t                 rd_data_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    // Write and read the payload memory
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // Set or drop valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.valid_set)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (wr.valid_clr)
        begin
            valid_reg[wr_idx] <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

// ===== rtl/core/pdt_seq.sv =====
// Sequencer: slot scan, age check and table update over the shared unit.
module pdt_seq
    import pdt_pkg::*;
#(
    parameter int SLOT_COUNT      = 8,
    parameter int FRAME_MAX_BYTES = 255,
    parameter int IDX_W           = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  in_item_t              item,
    output logic                  busy,
    input  cfg_t                  cfg,
    output alu_req_t              alu_req,
    input  alu_rsp_t              alu_rsp,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_idx,
    input  slot_t                 rd_data,
    input  logic [SLOT_COUNT-1:0] valid,
    output logic [IDX_W-1:0]      wr_idx,
    output slot_wr_t              wr,
    output out_item_t             result,
    output logic                  result_valid
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [7:0]       LEN_MAX  = 8'(FRAME_MAX_BYTES);

    state_t           state_reg, state_next;
    in_item_t         in_reg;
    in_item_t         in_sat;
    slot_t            hit_reg;
    logic [IDX_W-1:0] iss_idx_reg;
    logic             iss_done_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             bcast_reg;
    logic [31:0]      diff_reg;
    logic             expired_reg;
    out_item_t        result_reg, result_next;
    logic             result_valid_reg;

    logic             match_now;
    logic             free_now;
    logic             scan_end;
    logic [7:0]       att_inc;

    assign match_now = cmp_vld_reg && valid[cmp_idx_reg] && alu_rsp.zero;
    assign free_now  = cmp_vld_reg && !valid[cmp_idx_reg] && !free_reg;
    assign scan_end  = cmp_vld_reg && (match_now || cmp_idx_reg == LAST_IDX);
    assign att_inc   = (hit_reg.att == ATT_MAX) ? ATT_MAX : hit_reg.att + 8'd1;

    // Clamp the frame length of the incoming word
    always_comb
    begin
        in_sat = item;
        if (item.frame_length > LEN_MAX)
        begin
            in_sat.frame_length = LEN_MAX;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = (match_now && in_reg.kind == KIND_HEARD) ? S_AGE : S_WRITE;
                end
            end
            S_AGE:   state_next = S_TTL;
            S_TTL:   state_next = S_WRITE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: operand select, memory access, update and result
    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        rd_en       = 1'b0;
        rd_idx      = iss_idx_reg;
        alu_req.a   = {16'b0, in_reg.node_address};
        alu_req.b   = {16'b0, cfg.bcast};
        wr_idx      = match_reg ? match_idx_reg : free_idx_reg;
        wr          = '0;
        result_next = '0;
        result_next.status = STAT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en = 1'b0;
            end
            S_SCAN:
            begin
                rd_en = !iss_done_reg;
                if (cmp_vld_reg)
                begin
                    alu_req.b = {16'b0, rd_data.addr};
                end
            end
            S_AGE:
            begin
                alu_req.a = in_reg.epoch_now;
                alu_req.b = hit_reg.stamp;
            end
            S_TTL:
            begin
                alu_req.a = {16'b0, cfg.ttl};
                alu_req.b = diff_reg;
            end
            S_WRITE:
            begin
                case (in_reg.kind)
                    KIND_ENQ:
                    begin
                        if (match_reg || free_reg)
                        begin
                            wr.we         = 1'b1;
                            wr.data.addr  = in_reg.node_address;
                            wr.data.tag   = in_reg.frame_tag;
                            wr.data.len   = in_reg.frame_length;
                            wr.data.stamp = in_reg.epoch_now;
                            wr.data.att   = 8'd0;
                            if (bcast_reg)
                            begin
                                wr.valid_clr              = 1'b1;
                                result_next.status        = STAT_BCAST;
                                result_next.send_valid    = 1'b1;
                                result_next.send_tag      = in_reg.frame_tag;
                                result_next.send_length   = in_reg.frame_length;
                            end
                            else
                            begin
                                wr.valid_set       = 1'b1;
                                result_next.status = match_reg ? STAT_REPLACED : STAT_HELD;
                            end
                        end
                        else
                        begin
                            result_next.status = STAT_FULL;
                        end
                    end
                    KIND_HEARD:
                    begin
                        if (match_reg && expired_reg)
                        begin
                            wr.valid_clr       = 1'b1;
                            result_next.status = STAT_EXPIRED;
                        end
                        else if (match_reg)
                        begin
                            wr.we                     = 1'b1;
                            wr.data                   = hit_reg;
                            wr.data.att               = att_inc;
                            result_next.status        = STAT_SENT;
                            result_next.send_valid    = 1'b1;
                            result_next.send_tag      = hit_reg.tag;
                            result_next.send_length   = hit_reg.len;
                            result_next.send_attempts = att_inc;
                        end
                    end
                    KIND_ACK:
                    begin
                        if (match_reg)
                        begin
                            wr.valid_clr       = 1'b1;
                            result_next.status = STAT_ACKED;
                        end
                        else
                        begin
                            result_next.status = STAT_ACK_MISS;
                        end
                    end
                    default:
                    begin
                        result_next.status = STAT_NONE;
                    end
                endcase
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Advance state and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            iss_idx_reg      <= '0;
            iss_done_reg     <= 1'b0;
            cmp_vld_reg      <= 1'b0;
            cmp_idx_reg      <= '0;
            match_reg        <= 1'b0;
            match_idx_reg    <= '0;
            free_reg         <= 1'b0;
            free_idx_reg     <= '0;
            bcast_reg        <= 1'b0;
            expired_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmp_vld_reg      <= rd_en;
            cmp_idx_reg      <= iss_idx_reg;
            result_valid_reg <= (state_reg == S_WRITE);
            if (state_reg == S_IDLE)
            begin
                iss_idx_reg  <= '0;
                iss_done_reg <= 1'b0;
                match_reg    <= 1'b0;
                free_reg     <= 1'b0;
                expired_reg  <= 1'b0;
            end
            if (rd_en)
            begin
                if (iss_idx_reg == LAST_IDX)
                begin
                    iss_done_reg <= 1'b1;
                end
                else
                begin
                    iss_idx_reg <= iss_idx_reg + 1'b1;
                end
            end
            // Compare broadcast address while the first read is in flight
            if (state_reg == S_SCAN && !cmp_vld_reg)
            begin
                bcast_reg <= alu_rsp.zero;
            end
            if (state_reg == S_SCAN && match_now)
            begin
                match_reg     <= 1'b1;
                match_idx_reg <= cmp_idx_reg;
            end
            if (state_reg == S_SCAN && free_now)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
            if (state_reg == S_TTL)
            begin
                expired_reg <= (in_reg.epoch_now != 32'd0) && (hit_reg.stamp != 32'd0)
                               && alu_rsp.borrow;
            end
        end
    end

    // Hold input word, hit entry, age and result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            in_reg <= in_sat;
        end
        if (state_reg == S_SCAN && match_now)
        begin
            hit_reg <= rd_data;
        end
        if (state_reg == S_AGE)
        begin
            diff_reg <= alu_rsp.diff;
        end
        if (state_reg == S_WRITE)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `include "pending_downlink_table_core_assert.svh"

    `PDT_ASSERT_NEXT(a_start_scans, state_reg == S_IDLE && start, state_reg == S_SCAN)
    `PDT_ASSERT_SAME(a_strobe_after_write, result_valid, $past(state_reg) == S_WRITE)
    `PDT_ASSERT_SAME(a_send_status, result_valid && result.send_valid,
        result.status == STAT_SENT || result.status == STAT_BCAST)
    `PDT_ASSERT_NEXT(a_age_then_ttl, state_reg == S_AGE, state_reg == S_TTL)

endmodule

// ===== rtl/core/pending_downlink_table_core.sv =====
// Pending downlink table: top level tying registers, sequencer, unit and slot store.
//
// Use: raise start with an event word on item while busy is low; the word is
// taken at that edge and busy stays high until the event is done. Kinds are
// enqueue frame, node heard and acknowledgement. Exactly one result word per
// event appears on result for one cycle, marked by result_valid; the receiver
// cannot stall it and must take it in that cycle.
// An event scans the slots one per cycle through the slot memory's single
// registered read port, with the shared subtract unit comparing each
// address; the scan stops at the matching slot and otherwise runs to the
// last slot. A node heard with a matching slot then passes the age and
// time-to-live checks (S_AGE, S_TTL) before the table update in S_WRITE.
// A new event may be started in the cycle the result strobe is shown.
// Configuration is written by the user over the APB port only while busy is low;
// the block itself does not enforce this. Reset clears all slot valid bits, sets
// ttl to 1800 s and the broadcast address to 65535; no clearing pass is needed.
module pending_downlink_table_core
    import pdt_pkg::*;
#(
    parameter int SLOT_COUNT      = 8,
    parameter int FRAME_MAX_BYTES = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    output logic        busy,
    output out_item_t   result,
    output logic        result_valid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    cfg_t                  cfg;
    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    slot_t                 rd_data;
    logic [IDX_W-1:0]      wr_idx;
    slot_wr_t              wr;
    logic [SLOT_COUNT-1:0] valid;

    // Configuration registers
    pdt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared subtract unit
    pdt_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Slot storage
    pdt_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_idx  (wr_idx),
        .wr      (wr),
        .valid   (valid)
    );

    // Event sequencer
    pdt_seq #(
        .SLOT_COUNT      (SLOT_COUNT),
        .FRAME_MAX_BYTES (FRAME_MAX_BYTES),
        .IDX_W           (IDX_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .cfg          (cfg),
        .alu_req      (alu_req),
        .alu_rsp      (alu_rsp),
        .rd_en        (rd_en),
        .rd_idx       (rd_idx),
        .rd_data      (rd_data),
        .valid        (valid),
        .wr_idx       (wr_idx),
        .wr           (wr),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
